[rtl/pli_pkg.sv]
`timescale 1ns / 1ps

package pli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int ENTRY_W    = 6;
  localparam int COUNT_W    = 7;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DCNT_W     = $clog2(PROD_W);
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 104;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(2);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOR   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEGEN = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_FIN,
    S_OUT
  } pli_state_t;

  typedef struct packed {
    logic load_wr;
    logic query_start;
    logic scan_step;
    logic seg_latch;
    logic set_oor;
    logic set_degen;
    logic mul_go;
    logic div_step;
    logic fin_go;
    logic out_load;
  } pli_cmd_t;

  typedef struct packed {
    logic few_points;
    logic cmp_valid;
    logic hit;
    logic degen;
    logic last;
    logic div_done;
  } pli_stat_t;

endpackage

[rtl/pli_ctrl.sv]
`timescale 1ns / 1ps

module pli_ctrl
  import pli_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      opcode,
  input  logic      out_tready,
  output logic      out_tvalid,
  input  pli_stat_t stat,
  output pli_cmd_t  cmd
);

  pli_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            if (stat.few_points) begin
              cmd.set_oor = 1'b1;
              state_nxt   = S_OUT;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (stat.cmp_valid && stat.hit) begin
          if (stat.degen) begin
            cmd.set_degen = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            cmd.seg_latch = 1'b1;
            state_nxt     = S_MUL;
          end
        end else if (stat.cmp_valid && stat.last) begin
          cmd.set_oor = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin_go = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

[rtl/pli_dp.sv]
`timescale 1ns / 1ps

module pli_dp
  import pli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pli_cmd_t                 cmd,
  output pli_stat_t                stat,
  input  logic                     cfg_wr_en,
  input  logic [COUNT_W-1:0]       cfg_wr_data,
  input  logic [ENTRY_W-1:0]       entry_index,
  input  logic signed [DATA_W-1:0] point_x,
  input  logic signed [DATA_W-1:0] point_y,
  input  logic signed [DATA_W-1:0] query_x,
  output logic signed [DATA_W-1:0] result_y,
  output logic [STAT_W-1:0]        status
);

  logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
  logic signed [DATA_W-1:0] y_mem [MAX_POINTS];

  logic [COUNT_W-1:0]       pc_r;
  logic [IDX_W-1:0]         n_eff;
  logic [IDX_W-1:0]         idx_r;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     wr_ok;
  logic signed [DATA_W-1:0] rd_x_r, rd_y_r;
  logic signed [DATA_W-1:0] prev_x_r, prev_y_r;
  logic signed [DATA_W-1:0] qx_r, y1_r;
  logic [DATA_W-1:0]        dx_r, dy_r, dq_r;
  logic                     neg_r;
  logic signed [DATA_W:0]   dx_w, dy_w, dq_w;
  logic [PROD_W-1:0]        quo_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W:0]          rem_sh;
  logic                     q_bit;
  logic [DCNT_W-1:0]        dcnt_r;
  logic signed [DATA_W-1:0] res_r;
  logic [STAT_W-1:0]        stat_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]        out_stat_r;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] a;
    a = v[DATA_W] ? -v : v;
    return a[DATA_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      pc_r <= cfg_wr_data;
    end
  end

  assign n_eff   = (int'(pc_r) > MAX_POINTS) ? IDX_W'(MAX_POINTS) : IDX_W'(pc_r);
  assign wr_ok   = (int'(entry_index) < MAX_POINTS);
  assign wr_addr = ADDR_W'(entry_index);
  assign rd_addr = cmd.query_start ? '0 : idx_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      x_mem[wr_addr] <= point_x;
      y_mem[wr_addr] <= point_y;
    end
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
  end

  assign dx_w = {rd_x_r[DATA_W-1], rd_x_r} - {prev_x_r[DATA_W-1], prev_x_r};
  assign dy_w = {rd_y_r[DATA_W-1], rd_y_r} - {prev_y_r[DATA_W-1], prev_y_r};
  assign dq_w = {qx_r[DATA_W-1], qx_r} - {prev_x_r[DATA_W-1], prev_x_r};

  always_comb begin
    stat.few_points = (n_eff < IDX_W'(2));
    stat.cmp_valid  = (idx_r >= IDX_W'(2));
    stat.hit        = ((qx_r >= prev_x_r) && (qx_r <= rd_x_r)) ||
                      ((qx_r <= prev_x_r) && (qx_r >= rd_x_r));
    stat.degen      = (prev_x_r == rd_x_r);
    stat.last       = (idx_r == n_eff);
    stat.div_done   = (dcnt_r == '1);
  end

  assign rem_sh = {rem_r, quo_r[PROD_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dx_r});

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      idx_r <= IDX_W'(1);
      qx_r  <= query_x;
    end else if (cmd.scan_step) begin
      idx_r    <= idx_r + IDX_W'(1);
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    if (cmd.seg_latch) begin
      y1_r  <= prev_y_r;
      dx_r  <= mag(dx_w);
      dy_r  <= mag(dy_w);
      dq_r  <= mag(dq_w);
      neg_r <= dx_w[DATA_W] ^ dy_w[DATA_W] ^ dq_w[DATA_W];
    end
    if (cmd.mul_go) begin
      quo_r  <= PROD_W'(dy_r) * PROD_W'(dq_r);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? DATA_W'(rem_sh - {1'b0, dx_r}) : rem_sh[DATA_W-1:0];
      quo_r  <= {quo_r[PROD_W-2:0], q_bit};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.set_oor) begin
      res_r  <= '0;
      stat_r <= STAT_OOR;
    end else if (cmd.set_degen) begin
      res_r  <= prev_y_r;
      stat_r <= STAT_DEGEN;
    end else if (cmd.fin_go) begin
      res_r  <= neg_r ? y1_r - $signed(quo_r[DATA_W-1:0])
                      : y1_r + $signed(quo_r[DATA_W-1:0]);
      stat_r <= STAT_OK;
    end
    if (cmd.out_load) begin
      out_data_r <= res_r;
      out_stat_r <= stat_r;
    end
  end

  assign result_y = out_data_r;
  assign status   = out_stat_r;

endmodule

[rtl/piecewise_linear_interpolation.sv]
// Load item: written into the table; it gives no result.
// Query item: the segment scan (one table entry per cycle), a multiply, 64 bit-serial
// divide steps and a final add or subtract give the result.
// One item is worked at a time; a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears control and sets point_count to 2;
// table contents are undefined until loaded.
`timescale 1ns / 1ps

module piecewise_linear_interpolation
  import pli_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index[5:0], point_x[37:6], point_y[69:38], query_x[101:70], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_y[31:0]
  output logic [DATA_W-1:0]     out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]     out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [COUNT_W-1:0]    cfg_wr_data
);

  pli_cmd_t                 cmd;
  pli_stat_t                stat;
  logic signed [DATA_W-1:0] result_y;

  pli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .opcode     (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  pli_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .entry_index (in_tdata[5:0]),
    .point_x     (in_tdata[37:6]),
    .point_y     (in_tdata[69:38]),
    .query_x     (in_tdata[101:70]),
    .result_y    (result_y),
    .status      (out_tuser)
  );

  assign out_tdata = result_y;

endmodule

[rtl/pli_chk.sv]
`timescale 1ns / 1ps

module pli_chk
  import pli_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [DATA_W-1:0]    out_tdata,
  input logic [STAT_W-1:0]    out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STAT_OK || out_tuser == STAT_OOR ||
                    out_tuser == STAT_DEGEN))
    else $error("bad status code");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_OOR) |-> (out_tdata == '0))
    else $error("out of range result not zero");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load item produced a result");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind piecewise_linear_interpolation pli_chk u_pli_chk (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb
  import pli_pkg::*;
();

  typedef struct packed {
    logic [DATA_W-1:0] result_y;
    logic [STAT_W-1:0] status;
  } interp_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [DATA_W-1:0]    out_tdata;
  logic [STAT_W-1:0]    out_tuser;
  logic                 cfg_wr_en;
  logic [COUNT_W-1:0]   cfg_wr_data;

  logic signed [DATA_W-1:0] x_tab [MAX_POINTS];
  logic signed [DATA_W-1:0] y_tab [MAX_POINTS];
  logic [COUNT_W-1:0]       active_count;

  interp_result_t pending_results [$];
  interp_result_t want;
  int             error_count;
  int             items_sent;
  bit             idle_on;
  bit             hold_req;

  piecewise_linear_interpolation DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic int used_points();
    return (active_count > MAX_POINTS) ? MAX_POINTS : int'(active_count);
  endfunction

  function automatic interp_result_t interpolate(input logic signed [DATA_W-1:0] qx);
    interp_result_t r;
    int             n;
    longint         x1, x2, y1, y2, q, dx, dy, dq, res;
    bit [63:0]      mdx, mdy, mdq, quot;
    bit             neg;
    r.result_y = '0;
    r.status   = STAT_OOR;
    n = used_points();
    q = longint'(qx);
    if (n < 2) return r;
    for (int i = 0; i + 1 < n; i++) begin
      x1 = longint'(x_tab[i]);
      x2 = longint'(x_tab[i+1]);
      y1 = longint'(y_tab[i]);
      y2 = longint'(y_tab[i+1]);
      if ((q >= x1 && q <= x2) || (q <= x1 && q >= x2)) begin
        if (x1 == x2) begin
          r.result_y = y1[DATA_W-1:0];
          r.status   = STAT_DEGEN;
          return r;
        end
        dx  = x2 - x1;
        dy  = y2 - y1;
        dq  = q - x1;
        neg = ((dy < 0) != (dq < 0)) != (dx < 0);
        mdx = (dx < 0) ? -dx : dx;
        mdy = (dy < 0) ? -dy : dy;
        mdq = (dq < 0) ? -dq : dq;
        quot = (mdy * mdq) / mdx;
        res = neg ? y1 - longint'(quot) : y1 + longint'(quot);
        r.result_y = res[DATA_W-1:0];
        r.status   = STAT_OK;
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_between(input longint lo, input longint hi);
    bit [63:0] span, r;
    span = 64'(hi - lo) + 64'd1;
    r = {$urandom, $urandom};
    return 32'(lo + longint'(r % span));
  endfunction

  function automatic logic [DATA_W-1:0] pick_query(input int n);
    int     i;
    longint a, b;
    if (n < 2) return rand_val();
    i = $urandom_range(0, n - 2);
    a = longint'(x_tab[i]);
    b = longint'(x_tab[i+1]);
    case ($urandom_range(0, 5))
      0, 1, 2: return (a < b) ? rand_between(a, b) : rand_between(b, a);
      3: return x_tab[$urandom_range(0, n - 1)];
      default: return rand_val();
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [ENTRY_W-1:0] idx,
                           input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                           input logic [DATA_W-1:0] qx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, qx, py, px, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (op == OP_LOAD) begin
      x_tab[idx] = px;
      y_tab[idx] = py;
    end else begin
      pending_results.insert(pending_results.size(), interpolate(qx));
    end
  endtask

  task automatic load_point(input int idx, input logic [DATA_W-1:0] px,
                            input logic [DATA_W-1:0] py);
    send_item(OP_LOAD, ENTRY_W'(idx), px, py, $urandom);
  endtask

  task automatic query_at(input logic [DATA_W-1:0] qx);
    send_item(OP_QUERY, ENTRY_W'($urandom), $urandom, $urandom, qx);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    active_count = value;
  endtask

  task automatic load_table(input int n);
    int     mode;
    longint cur;
    mode = $urandom_range(0, 2);
    cur  = longint'($urandom_range(0, 32'h7fff_ffff)) - 64'sh4000_0000;
    for (int i = 0; i < n; i++) begin
      if (mode == 2) begin
        load_point(i, rand_val(), rand_val());
      end else begin
        load_point(i, 32'(cur), rand_val());
        if ($urandom_range(0, 7) != 0) begin
          if (mode == 0) cur = cur + $urandom_range(0, 32'h0100_0000);
          else cur = cur - $urandom_range(0, 32'h0100_0000);
        end
      end
    end
  endtask

  task automatic test_two_points();
    load_point(0, 32'h0000_0000, 32'h0000_0000);
    load_point(1, 32'h0004_0000, 32'h0008_0000);
    query_at(32'h0001_8000);
    query_at(32'h0000_0000);
    query_at(32'h0004_0000);
    query_at(32'hffff_ffff);
    query_at(32'h0004_0001);
    load_point(1, 32'h0003_0000, 32'hfff9_0000);
    query_at(32'h0001_0000);
  endtask

  task automatic test_falling_x();
    load_point(0, 32'h0003_0000, 32'h0001_0000);
    load_point(1, 32'hfffb_0000, 32'h000a_0000);
    query_at(32'h0000_0000);
    query_at(32'hfffb_0000);
    query_at(32'h0004_0000);
  endtask

  task automatic test_extremes();
    load_point(0, 32'h8000_0000, 32'h7fff_ffff);
    load_point(1, 32'h7fff_ffff, 32'h8000_0000);
    query_at(32'h8000_0000);
    query_at(32'h7fff_ffff);
    query_at(32'h0000_0000);
    query_at(32'hffff_ffff);
    load_point(0, 32'h7fff_ffff, 32'h8000_0000);
    load_point(1, 32'h8000_0000, 32'h7fff_ffff);
    query_at(32'h0000_0001);
  endtask

  task automatic test_degenerate();
    load_point(0, 32'h0005_0000, 32'h0007_0000);
    load_point(1, 32'h0005_0000, 32'hfffe_0000);
    query_at(32'h0005_0000);
    query_at(32'h0006_0000);
  endtask

  task automatic test_count_limits();
    set_point_count(COUNT_W'(0));
    query_at(32'h0005_0000);
    set_point_count(COUNT_W'(1));
    query_at(32'h0005_0000);
    load_table(MAX_POINTS);
    set_point_count(COUNT_W'(MAX_POINTS));
    query_at(pick_query(MAX_POINTS));
    query_at(x_tab[MAX_POINTS-1]);
    set_point_count(COUNT_W'(127));
    query_at(pick_query(MAX_POINTS));
    query_at(rand_val());
  endtask

  task automatic test_random(input int target);
    int n, burst;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0: set_point_count(COUNT_W'($urandom_range(0, 1)));
        1: set_point_count(COUNT_W'(MAX_POINTS));
        2: set_point_count(COUNT_W'($urandom_range(MAX_POINTS + 1, 127)));
        3: set_point_count(COUNT_W'($urandom_range(9, MAX_POINTS - 1)));
        default: set_point_count(COUNT_W'($urandom_range(2, 8)));
      endcase
      n = used_points();
      if (n >= 2) load_table(n);
      burst = $urandom_range(20, 50);
      repeat (burst) begin
        if ($urandom_range(0, 6) == 0) load_point($urandom_range(0, MAX_POINTS - 1),
                                                  rand_val(), rand_val());
        else query_at(pick_query(n));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) query_at(pick_query(used_points()));
    drain();
  endtask

  task automatic test_steady();
    idle_on = 1'b0;
    repeat (60) begin
      if ($urandom_range(0, 5) == 0) load_point($urandom_range(0, MAX_POINTS - 1),
                                                rand_val(), rand_val());
      else query_at(pick_query(used_points()));
    end
  endtask

  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result_y: expected none, got %h (status %0d)", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.result_y) begin
          $error("result_y: expected %h, got %h", want.result_y, out_tdata);
          error_count++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= OP_LOAD;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    active_count = COUNT_RESET;
    error_count  = 0;
    items_sent   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_two_points();
    test_falling_x();
    test_extremes();
    test_degenerate();
    test_count_limits();
    test_random(540);
    test_backpressure();
    test_steady();

    drain();
    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
